### design/ate_pkg.sv
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types, command codes and helpers for the affine transform engine.
// ----------------------------------------------------------------------------
package ate_pkg;

    localparam int ELEM_W    = 32;
    localparam int MAT_DEPTH = 16;
    localparam int PROD_W    = 48;   // 64-bit product after >>> 16
    localparam int SUM_W     = 50;   // three products plus one element

    typedef logic [2:0] cmd_t;

    localparam cmd_t CMD_LOAD      = 3'd0;
    localparam cmd_t CMD_READ      = 3'd1;
    localparam cmd_t CMD_TRANSLATE = 3'd2;
    localparam cmd_t CMD_SCALE     = 3'd3;
    localparam cmd_t CMD_POINT     = 3'd4;

    localparam logic [ELEM_W-1:0] FRAC_ONE = 32'h0001_0000;

    typedef logic [MAT_DEPTH-1:0][ELEM_W-1:0] mat_t;
    typedef logic [11:0][ELEM_W-1:0]          scaled_t;   // rows 0..2, row-major
    typedef logic [3:0][ELEM_W-1:0]           colsum_t;

    // matrix update controls, datapath side to store
    typedef struct packed {
        logic       load;
        logic       translate;
        logic       scale;
        logic [3:0] idx;
    } mat_ctrl_t;

    function automatic mat_t identity_mat();
        mat_t m;
        for (int i = 0; i < MAT_DEPTH; i++)
        begin
            m[i] = ((i % 5) == 0) ? FRAC_ONE : '0;
        end
        return m;
    endfunction

    function automatic logic [ELEM_W-1:0] sat32(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
        lo = {{(SUM_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};
        if (v > hi)
        begin
            return hi[ELEM_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[ELEM_W-1:0];
        end
        return v[ELEM_W-1:0];
    endfunction

endpackage

### design/ate_datapath.sv
// ----------------------------------------------------------------------------
// ate_datapath
// Twelve Q16.16 multipliers (operand r times row r) with floor shift, the
// saturated lone products for scale and the saturated column sums for
// translate and point transform.
// ----------------------------------------------------------------------------
module ate_datapath
(
    input  ate_pkg::mat_t                   mat,
    input  logic signed [ate_pkg::ELEM_W-1:0] op_x,
    input  logic signed [ate_pkg::ELEM_W-1:0] op_y,
    input  logic signed [ate_pkg::ELEM_W-1:0] op_z,
    output ate_pkg::scaled_t                scaled,
    output ate_pkg::colsum_t                colsum
);

    logic signed [ate_pkg::ELEM_W-1:0]   op [3];
    logic signed [ate_pkg::PROD_W-1:0]   prod [12];

    assign op[0] = op_x;
    assign op[1] = op_y;
    assign op[2] = op_z;

    always_comb
    begin
        logic signed [2*ate_pkg::ELEM_W-1:0] full;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                full = op[r] * $signed(mat[r*4+c]);
                // top bits of the arithmetic shift give the floor
                prod[r*4+c] = full[2*ate_pkg::ELEM_W-1:16];
            end
        end
    end

    always_comb
    begin
        logic signed [ate_pkg::SUM_W-1:0] s;
        for (int i = 0; i < 12; i++)
        begin
            scaled[i] = ate_pkg::sat32(ate_pkg::SUM_W'(prod[i]));
        end
        for (int c = 0; c < 4; c++)
        begin
            s = ate_pkg::SUM_W'(prod[c]) + ate_pkg::SUM_W'(prod[4+c])
              + ate_pkg::SUM_W'(prod[8+c]) + ate_pkg::SUM_W'($signed(mat[12+c]));
            colsum[c] = ate_pkg::sat32(s);
        end
    end

endmodule

### design/ate_matrix.sv
// ----------------------------------------------------------------------------
// ate_matrix
// The 4x4 Q16.16 matrix, held in flops, reset to identity. Applies element
// loads, the row 3 update of translate and the row scaling.
// ----------------------------------------------------------------------------
module ate_matrix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ate_pkg::mat_ctrl_t          ctrl,
    input  logic [ate_pkg::ELEM_W-1:0]  load_value,
    input  ate_pkg::scaled_t            scaled,
    input  ate_pkg::colsum_t            colsum,
    output ate_pkg::mat_t               mat
);

    ate_pkg::mat_t mat_reg;
    ate_pkg::mat_t mat_next;

    always_comb
    begin
        mat_next = mat_reg;
        if (ctrl.load)
        begin
            mat_next[ctrl.idx] = load_value;
        end
        if (ctrl.translate)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat_next[12+c] = colsum[c];
            end
        end
        if (ctrl.scale)
        begin
            for (int i = 0; i < 12; i++)
            begin
                mat_next[i] = scaled[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= ate_pkg::identity_mat();
        end
        else
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

### design/affine_transform_engine_core.sv
// ----------------------------------------------------------------------------
// affine_transform_engine_core
// 4x4 row-vector affine transform engine, signed Q16.16.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per clock sustained while the output
// is not stalled. A beat sits in the input register while twelve parallel
// multipliers and the column adders work on it against the current matrix;
// the result lands in the output register and any matrix update takes effect
// at the same edge, so the next beat already sees it. Commands: load element,
// read element, translate (row3 += x*row0 + y*row1 + z*row2), scale rows
// 0..2 by x, y, z, and point transform; products are floored after >> 16 and
// every sum saturates.
module affine_transform_engine_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] command, [4:3] row, [6:5] col, [38:7] in_x, [70:39] in_y,
    // [102:71] in_z, [103] zero
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [95:0]  m_axis_tdata
);

    localparam int W = ate_pkg::ELEM_W;

    logic                a_valid_reg;
    logic                a_valid_next;
    ate_pkg::cmd_t       a_cmd_reg;
    logic [1:0]          a_row_reg;
    logic [1:0]          a_col_reg;
    logic signed [W-1:0] a_x_reg;
    logic signed [W-1:0] a_y_reg;
    logic signed [W-1:0] a_z_reg;

    logic                b_valid_reg;
    logic                b_valid_next;
    logic [W-1:0]        b_x_reg;
    logic [W-1:0]        b_y_reg;
    logic [W-1:0]        b_z_reg;
    logic [W-1:0]        b_x_next;
    logic [W-1:0]        b_y_next;
    logic [W-1:0]        b_z_next;

    logic                advance;
    logic                exec;
    logic                in_beat;

    ate_pkg::mat_t       mat;
    ate_pkg::scaled_t    scaled;
    ate_pkg::colsum_t    colsum;
    ate_pkg::mat_ctrl_t  mctrl;

    assign advance       = !b_valid_reg || m_axis_tready;
    assign s_axis_tready = !a_valid_reg || advance;
    assign exec          = a_valid_reg && advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign a_valid_next  = s_axis_tready ? s_axis_tvalid : a_valid_reg;
    assign b_valid_next  = advance ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            a_cmd_reg <= s_axis_tdata[2:0];
            a_row_reg <= s_axis_tdata[4:3];
            a_col_reg <= s_axis_tdata[6:5];
            a_x_reg   <= s_axis_tdata[38:7];
            a_y_reg   <= s_axis_tdata[70:39];
            a_z_reg   <= s_axis_tdata[102:71];
        end
        if (exec)
        begin
            b_x_reg <= b_x_next;
            b_y_reg <= b_y_next;
            b_z_reg <= b_z_next;
        end
    end

    ate_datapath u_datapath
    (
        .mat    (mat),
        .op_x   (a_x_reg),
        .op_y   (a_y_reg),
        .op_z   (a_z_reg),
        .scaled (scaled),
        .colsum (colsum)
    );

    always_comb
    begin
        mctrl.load      = 1'b0;
        mctrl.translate = 1'b0;
        mctrl.scale     = 1'b0;
        mctrl.idx       = {a_row_reg, a_col_reg};
        b_x_next        = '0;
        b_y_next        = '0;
        b_z_next        = '0;
        unique case (a_cmd_reg)
            ate_pkg::CMD_LOAD:
            begin
                mctrl.load = exec;
            end
            ate_pkg::CMD_READ:
            begin
                b_x_next = mat[{a_row_reg, a_col_reg}];
            end
            ate_pkg::CMD_TRANSLATE:
            begin
                mctrl.translate = exec;
            end
            ate_pkg::CMD_SCALE:
            begin
                mctrl.scale = exec;
            end
            ate_pkg::CMD_POINT:
            begin
                b_x_next = colsum[0];
                b_y_next = colsum[1];
                b_z_next = colsum[2];
            end
            default:
            begin
                b_x_next = '0;
            end
        endcase
    end

    ate_matrix u_matrix
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mctrl),
        .load_value (a_x_reg),
        .scaled     (scaled),
        .colsum     (colsum),
        .mat        (mat)
    );

    assign m_axis_tvalid = b_valid_reg;
    assign m_axis_tdata  = {b_z_reg, b_y_reg, b_x_reg};

`ifndef SYNTHESIS
    // a held beat only waits behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !s_axis_tready) |-> (b_valid_reg && !m_axis_tready))
        else $error("input stage stalled without a blocked result");

    // the matrix only moves when a beat executes
    mat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(mat))
        else $error("matrix changed with no beat executing");

    // a read result carries zeros in y and z
    read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && a_cmd_reg == ate_pkg::CMD_READ) |=>
            (m_axis_tvalid && m_axis_tdata[95:32] == '0))
        else $error("read result malformed");
`endif

endmodule
